// ===== rtl/core/slt_pkg.sv =====
// Shared types and codes for the sorted list table.
`timescale 1ns / 1ps

package slt_pkg;

   localparam int unsigned KeyWidth    = 32;
   localparam int unsigned CountOutW   = 6;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // broadcast to every cell in the execute cycle
   typedef struct packed {
      logic                       insert_en;
      logic                       delete_en;
      logic signed [KeyWidth-1:0] key;
   } cell_op_type;

   // what a cell reports back for the current key
   typedef struct packed {
      logic lt;   // occupied and holding a value below the key
      logic hit;  // first not-smaller slot, occupied and equal to the key
   } cell_flag_type;

endpackage

// ===== rtl/core/sorted_list_table_core.sv =====
// Sorted list table: ascending signed table built as a row of shifting cells.
`timescale 1ns / 1ps

// A bounded table of signed 32-bit values kept in ascending order, one value
// per cell. Each request transaction carries a command (insert, search,
// delete) and a value; each produces exactly one response transaction with a
// status and the entry count after the command (low 6 bits of the count).
// Insert places the value ahead of the first entry that is not smaller, so
// duplicates are kept; delete removes the first equal entry and closes the
// gap. A request is registered when taken and executed in the next cycle:
// every cell compares its entry against the key in parallel and then either
// keeps its value, takes the key, or takes a neighbour's entry. One
// transaction is in flight at a time, so no request is taken while one is
// executing; the response sits in an output register, and a new request is
// taken while a response is still waiting as long as that response is taken
// at the same edge. No clearing pass is needed after reset.
module sorted_list_table_core #(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic signed [slt_pkg::KeyWidth-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [slt_pkg::CountOutW-1:0]       rsp_entry_count
);

   localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned KeyW = slt_pkg::KeyWidth;
   localparam int unsigned OutW = slt_pkg::CountOutW;

   // request capture and execute control
   logic                   busy_ff;
   logic                   busy_in;
   slt_pkg::command_type   cmd_ff;
   logic signed [KeyW-1:0] key_ff;
   logic [CntW-1:0]        count_ff;
   logic [CntW-1:0]        count_in;

   // response register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   slt_pkg::status_type    rsp_status_ff;
   slt_pkg::status_type    status_in;
   logic [OutW-1:0]        rsp_count_ff;
   logic [CntW+OutW-1:0]   count_wide;

   logic                   req_take;
   logic                   table_empty;
   logic                   table_full;
   logic                   found;

   slt_pkg::cell_op_type   op;
   logic signed [KeyW-1:0] entries [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] lt_vec;
   logic [TABLE_DEPTH-1:0] hit_vec;

   assign req_take    = req_valid && !req_stall;
   assign req_stall   = busy_ff || (rsp_valid_ff && rsp_stall);
   assign table_empty = (count_ff == '0);
   assign table_full  = (count_ff == CntW'(TABLE_DEPTH));
   assign found       = |hit_vec;

   // -------------------------------------------------------------------
   // Command decode for the execute cycle
   // -------------------------------------------------------------------
   always_comb begin
      op.key       = key_ff;
      op.insert_en = 1'b0;
      op.delete_en = 1'b0;
      status_in    = slt_pkg::ST_NOT_FOUND;
      count_in     = count_ff;
      unique case (cmd_ff) inside
         slt_pkg::CMD_INSERT: begin
            if (table_full) begin
               status_in = slt_pkg::ST_FULL;
            end else begin
               status_in    = slt_pkg::ST_DONE;
               op.insert_en = busy_ff;
               if (busy_ff) count_in = count_ff + CntW'(1);
            end
         end
         slt_pkg::CMD_SEARCH, slt_pkg::CMD_DELETE: begin
            if (table_empty) begin
               status_in = slt_pkg::ST_EMPTY;
            end else if (found) begin
               status_in = slt_pkg::ST_DONE;
               if (cmd_ff == slt_pkg::CMD_DELETE && busy_ff) begin
                  op.delete_en = 1'b1;
                  count_in     = count_ff - CntW'(1);
               end
            end else begin
               status_in = slt_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = slt_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   // -------------------------------------------------------------------
   // Cell row: slot 0 holds the smallest entry
   // -------------------------------------------------------------------
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic                   occ;
      logic                   left_lt;
      logic signed [KeyW-1:0] left_entry;
      logic signed [KeyW-1:0] right_entry;
      slt_pkg::cell_flag_type flag;

      assign occ = (CntW'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = key_ff;
      end else begin : g_inner
         assign left_lt    = lt_vec[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_mid
         assign right_entry = entries[i+1];
      end

      slt_cell u_cell (
         .clock       (clock),
         .op          (op),
         .occupied    (occ),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .flag        (flag)
      );

      assign lt_vec[i]  = flag.lt;
      assign hit_vec[i] = flag.hit;
   end

   // -------------------------------------------------------------------
   // Control and response registers
   // -------------------------------------------------------------------
   assign busy_in      = req_take;
   assign rsp_valid_in = busy_ff || (rsp_valid_ff && rsp_stall);
   assign count_wide   = {{OutW{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= slt_pkg::command_type'(req_command);
         key_ff <= req_value;
      end
      if (busy_ff) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_wide[OutW-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== rtl/core/slt_cell.sv =====
// One slot of the sorted table: holds one entry and shifts it left or right.
`timescale 1ns / 1ps

module slt_cell (
   input  logic                                 clock,
   input  slt_pkg::cell_op_type                 op,
   input  logic                                 occupied,
   input  logic                                 left_lt,
   input  logic signed [slt_pkg::KeyWidth-1:0]  left_entry,
   input  logic signed [slt_pkg::KeyWidth-1:0]  right_entry,
   output logic signed [slt_pkg::KeyWidth-1:0]  entry,
   output slt_pkg::cell_flag_type               flag
);

   logic signed [slt_pkg::KeyWidth-1:0] entry_ff;
   logic signed [slt_pkg::KeyWidth-1:0] entry_in;
   logic                                lt;

   assign lt       = occupied && (entry_ff < op.key);
   assign flag.lt  = lt;
   assign flag.hit = occupied && !lt && left_lt && (entry_ff == op.key);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (op.insert_en && !lt) begin
         // boundary slot takes the key, slots above it take the left neighbour
         entry_in = left_lt ? op.key : left_entry;
      end else if (op.delete_en && !lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
